/* src/csp_pkg.sv */
`timescale 1ns / 1ps
package csp_pkg;

	localparam int DATA_W    = 32;
	localparam int FRAC_W    = 16;
	localparam int MAX_NODES = 64;
	localparam int ADDR_W    = $clog2(MAX_NODES);
	localparam int CNT_W     = 7;
	localparam int NUM_W     = DATA_W + FRAC_W + 1;
	localparam int DEN_W     = DATA_W + 1;
	localparam int SUM_W     = DATA_W + 4;
	localparam int DIV_STEPS = NUM_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	// divide by six as a multiply by ceil(2^34 / 6) and a shift, exact for 32-bit magnitudes
	localparam logic [DATA_W-1:0] DIV6_RECIP = 32'hAAAA_AAAB;
	localparam int                DIV6_SHIFT = 34;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_VALUE = 2'd1;
	localparam logic [1:0] CMD_SLOPE = 2'd2;
	localparam logic [1:0] CMD_CURV  = 2'd3;

	localparam logic signed [DATA_W-1:0] ONE_Q  = DATA_W'(1) << FRAC_W;
	localparam logic signed [DATA_W-1:0] SAT_HI = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] SAT_LO = {1'b1, {(DATA_W-1){1'b0}}};

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic signed [NUM_W-1:0]  num_t;
	typedef logic signed [DEN_W-1:0]  den_t;

	typedef struct packed {
		logic [1:0]        command;
		logic [ADDR_W-1:0] node_index;
		data_t             node_pos;
		data_t             node_value;
		data_t             node_curvature;
		data_t             query_pos;
	} item_t;

	typedef struct packed {
		data_t result_value;
		logic  zero_width_error;
	} result_t;

	// clamp a widened sum back into the data range
	function automatic data_t sat_sum(input sum_t v);
		data_t r;
		if (v[SUM_W-1:DATA_W-1] == {(SUM_W-DATA_W+1){v[SUM_W-1]}})
			r = v[DATA_W-1:0];
		else
			r = v[SUM_W-1] ? SAT_LO : SAT_HI;
		return r;
	endfunction

endpackage

/* src/csp_ram.sv */
`timescale 1ns / 1ps
module csp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* src/csp_mul.sv */
`timescale 1ns / 1ps
module csp_mul (
	input  logic           clk,
	input  csp_pkg::data_t a,
	input  csp_pkg::data_t b,
	output csp_pkg::data_t prod
);

	logic signed [2*csp_pkg::DATA_W-1:0] p;
	logic signed [2*csp_pkg::DATA_W-csp_pkg::FRAC_W-1:0] sh;
	csp_pkg::data_t prod_q;

	// full product, floor shift, saturate
	always_comb begin
		p  = a * b;
		sh = p[2*csp_pkg::DATA_W-1:csp_pkg::FRAC_W];
	end

	always_ff @(posedge clk) begin
		if (sh[$high(sh):csp_pkg::DATA_W-1] ==
		    {(2*csp_pkg::DATA_W-csp_pkg::FRAC_W-csp_pkg::DATA_W+1){sh[$high(sh)]}})
			prod_q <= sh[csp_pkg::DATA_W-1:0];
		else
			prod_q <= sh[$high(sh)] ? csp_pkg::SAT_LO : csp_pkg::SAT_HI;
	end

	assign prod = prod_q;

endmodule

/* src/csp_div.sv */
`timescale 1ns / 1ps
module csp_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  csp_pkg::num_t  num,
	input  csp_pkg::den_t  den,
	output logic           done,
	output csp_pkg::data_t quot
);

	localparam int NW = csp_pkg::NUM_W;
	localparam int DW = csp_pkg::DEN_W;

	logic [NW-1:0]                  quo_q;
	logic [DW-1:0]                  rem_q;
	logic [DW-1:0]                  den_q;
	logic                           neg_q;
	logic                           run_q;
	logic                           done_q;
	logic [csp_pkg::STEP_W-1:0]     cnt_q;
	csp_pkg::data_t                 quot_q;
	logic [DW:0]                    trial;
	logic                           fits;
	logic [NW-1:0]                  mag;
	logic [NW-1:0]                  neg_mag;
	logic                           ovf;

	// one restoring step per cycle
	always_comb begin
		trial = {rem_q, quo_q[NW-1]};
		fits  = trial >= {1'b0, den_q};
	end

	// final quotient bit joins the magnitude in the last step
	always_comb begin
		mag     = {quo_q[NW-2:0], fits};
		neg_mag = -mag;
		if (neg_q)
			ovf = (mag[NW-1:csp_pkg::DATA_W] != '0) ||
			      (mag[csp_pkg::DATA_W-1] && (mag[csp_pkg::DATA_W-2:0] != '0));
		else
			ovf = mag[NW-1:csp_pkg::DATA_W-1] != '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= csp_pkg::STEP_W'(csp_pkg::DIV_STEPS - 1);
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// operand capture and shift
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num[NW-1] ? NW'(-num) : NW'(num);
			den_q <= den[DW-1] ? DW'(-den) : DW'(den);
			neg_q <= num[NW-1] ^ den[DW-1];
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= fits ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
			quo_q <= mag;
			if (cnt_q == '0) begin
				if (ovf)
					quot_q <= neg_q ? csp_pkg::SAT_LO : csp_pkg::SAT_HI;
				else
					quot_q <= neg_q ? neg_mag[csp_pkg::DATA_W-1:0]
					                : mag[csp_pkg::DATA_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

/* src/cubic_spline_evaluator_top.sv */
`timescale 1ns / 1ps
// Cubic spline evaluator, signed Q16.16. A load word (command 0) writes one node in the
// cycle it is taken and keeps busy low. A query word holds busy high while a small sequencer
// walks the binary search (up to six halvings), reads both bracketing nodes, and then drives
// one shared 32x32 multiplier and one radix-2 divider; the division by six is a reciprocal
// multiply. A value query and a second derivative need two divisions, a first derivative
// three, and a zero-width interval ends the query without starting a division. The result
// appears on result for exactly one cycle with done high; the receiver cannot stall it, so it
// must take every word as it comes. node_count is to be written only while busy is low; the
// user must keep to this, as the block itself does not enforce it.
module cubic_spline_evaluator_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  csp_pkg::item_t   item,
	output logic             done,
	output csp_pkg::result_t result,
	input  logic             cfg_wen,
	input  logic [csp_pkg::CNT_W-1:0] cfg_data
);

	localparam int AW = csp_pkg::ADDR_W;

	localparam logic [5:0] S_IDLE  = 6'd0;
	localparam logic [5:0] S_SRCH  = 6'd1;
	localparam logic [5:0] S_CMP   = 6'd2;
	localparam logic [5:0] S_RDLO  = 6'd3;
	localparam logic [5:0] S_RDHI  = 6'd4;
	localparam logic [5:0] S_GOTHI = 6'd5;
	localparam logic [5:0] S_DX    = 6'd6;
	localparam logic [5:0] S_DA    = 6'd7;
	localparam logic [5:0] S_DB    = 6'd8;
	localparam logic [5:0] S_OP    = 6'd9;
	localparam logic [5:0] S_DIVW  = 6'd10;
	localparam logic [5:0] S_V0    = 6'd11;
	localparam logic [5:0] S_V1    = 6'd12;
	localparam logic [5:0] S_V2    = 6'd13;
	localparam logic [5:0] S_V3    = 6'd14;
	localparam logic [5:0] S_V4    = 6'd15;
	localparam logic [5:0] S_V5    = 6'd16;
	localparam logic [5:0] S_V6    = 6'd17;
	localparam logic [5:0] S_V7    = 6'd18;
	localparam logic [5:0] S_V8    = 6'd19;
	localparam logic [5:0] S_V9    = 6'd20;
	localparam logic [5:0] S_V10   = 6'd21;
	localparam logic [5:0] S_V11   = 6'd22;
	localparam logic [5:0] S_V12   = 6'd23;
	localparam logic [5:0] S_V13   = 6'd24;
	localparam logic [5:0] S_V14   = 6'd25;
	localparam logic [5:0] S_D1    = 6'd26;
	localparam logic [5:0] S_D2    = 6'd27;
	localparam logic [5:0] S_D3    = 6'd28;
	localparam logic [5:0] S_D4    = 6'd29;
	localparam logic [5:0] S_D5    = 6'd30;
	localparam logic [5:0] S_D6    = 6'd31;
	localparam logic [5:0] S_D7    = 6'd32;
	localparam logic [5:0] S_D8    = 6'd33;
	localparam logic [5:0] S_C1    = 6'd34;
	localparam logic [5:0] S_C2    = 6'd35;

	localparam logic [csp_pkg::FRAC_W-1:0] FRAC_ZERO = '0;

	logic [5:0]                  state_q;
	logic [5:0]                  ret_q;
	logic [csp_pkg::CNT_W-1:0]   node_count_q;
	logic [1:0]                  cmd_q;
	logic [AW-1:0]               lo_q;
	logic [AW-1:0]               hi_q;
	csp_pkg::data_t              x_q;
	csp_pkg::data_t              xlo_q, xhi_q, flo_q, fhi_q, clo_q, chi_q;
	csp_pkg::den_t               dx_q;
	csp_pkg::data_t              dxs_q;
	csp_pkg::data_t              a_q, b_q, lin_q, slope_q, t1_q, t2_q;
	csp_pkg::data_t              quot6_q;
	logic                        done_q;
	csp_pkg::result_t            result_q;

	logic                        accept;
	logic                        load_we;
	logic [AW-1:0]               last_idx;
	logic [AW:0]                 mid_sum;
	logic [AW-1:0]               mid;
	logic                        span_wide;
	logic [AW-1:0]               raddr;
	csp_pkg::data_t              pos_rd, val_rd, curv_rd;
	csp_pkg::data_t              mul_a, mul_b, prod;
	logic                        div_start, div_done;
	csp_pkg::num_t               div_num;
	csp_pkg::den_t               div_den;
	csp_pkg::data_t              quot;
	csp_pkg::den_t               xhi_x, x_xlo, fdiff;
	csp_pkg::data_t              prod_m1, prod3_m1;
	csp_pkg::data_t              div6_in, div6_res;
	logic [csp_pkg::DATA_W-1:0]  div6_mag, div6_quo;
	logic [2*csp_pkg::DATA_W-1:0] div6_prod;

	assign accept  = start && (state_q == S_IDLE);
	assign load_we = accept && (item.command == csp_pkg::CMD_LOAD);
	assign busy    = state_q != S_IDLE;

	// clamp node count into the usable range
	always_comb begin
		if (node_count_q < csp_pkg::CNT_W'(2))
			last_idx = AW'(1);
		else if (node_count_q > csp_pkg::CNT_W'(csp_pkg::MAX_NODES))
			last_idx = AW'(csp_pkg::MAX_NODES - 1);
		else
			last_idx = AW'(node_count_q - 1'b1);
	end

	// search midpoint and table read address
	always_comb begin
		mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
		mid       = mid_sum[AW:1];
		span_wide = ({1'b0, hi_q} - {1'b0, lo_q}) > (AW + 1)'(1);
		case (state_q)
			S_RDLO:  raddr = lo_q;
			S_RDHI:  raddr = hi_q;
			default: raddr = mid;
		endcase
	end

	csp_ram #(.WIDTH(csp_pkg::DATA_W), .DEPTH(csp_pkg::MAX_NODES)) u_pos_ram (
		.clk(clk), .we(load_we), .waddr(item.node_index), .wdata(item.node_pos),
		.raddr(raddr), .rdata(pos_rd)
	);

	csp_ram #(.WIDTH(csp_pkg::DATA_W), .DEPTH(csp_pkg::MAX_NODES)) u_val_ram (
		.clk(clk), .we(load_we), .waddr(item.node_index), .wdata(item.node_value),
		.raddr(raddr), .rdata(val_rd)
	);

	csp_ram #(.WIDTH(csp_pkg::DATA_W), .DEPTH(csp_pkg::MAX_NODES)) u_curv_ram (
		.clk(clk), .we(load_we), .waddr(item.node_index), .wdata(item.node_curvature),
		.raddr(raddr), .rdata(curv_rd)
	);

	csp_mul u_mul (
		.clk(clk), .a(mul_a), .b(mul_b), .prod(prod)
	);

	csp_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quot(quot)
	);

	// differences feeding the divider, and the product terms less one for the weights
	always_comb begin
		xhi_x    = csp_pkg::den_t'(xhi_q) - csp_pkg::den_t'(x_q);
		x_xlo    = csp_pkg::den_t'(x_q) - csp_pkg::den_t'(xlo_q);
		fdiff    = csp_pkg::den_t'(fhi_q) - csp_pkg::den_t'(flo_q);
		prod_m1  = csp_pkg::sat_sum(csp_pkg::sum_t'(prod) - csp_pkg::sum_t'(csp_pkg::ONE_Q));
		prod3_m1 = csp_pkg::sat_sum(csp_pkg::sum_t'(prod) + (csp_pkg::sum_t'(prod) <<< 1)
		                            - csp_pkg::sum_t'(csp_pkg::ONE_Q));
	end

	// divide by six, truncating toward zero, by reciprocal multiply on the magnitude
	always_comb begin
		div6_in   = (state_q == S_V13) ? prod : dxs_q;
		div6_mag  = div6_in[csp_pkg::DATA_W-1] ? csp_pkg::DATA_W'(-div6_in) : div6_in;
		div6_prod = {{csp_pkg::DATA_W{1'b0}}, div6_mag} *
		            {{csp_pkg::DATA_W{1'b0}}, csp_pkg::DIV6_RECIP};
		div6_quo  = csp_pkg::DATA_W'(div6_prod >> csp_pkg::DIV6_SHIFT);
		div6_res  = div6_in[csp_pkg::DATA_W-1] ? -div6_quo : div6_quo;
	end

	// operand selection for the shared multiplier and divider
	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = dx_q;
		case (state_q)
			S_DA: begin
				div_start = dx_q != '0;
				div_num   = {xhi_x, FRAC_ZERO};
			end
			S_DB: begin
				div_start = 1'b1;
				div_num   = {x_xlo, FRAC_ZERO};
			end
			S_OP: begin
				case (cmd_q)
					csp_pkg::CMD_VALUE: begin
						mul_a = a_q;
						mul_b = flo_q;
					end
					csp_pkg::CMD_SLOPE: begin
						div_start = 1'b1;
						div_num   = {fdiff, FRAC_ZERO};
					end
					default: begin
						mul_a = a_q;
						mul_b = clo_q;
					end
				endcase
			end
			S_V1: begin
				mul_a = b_q;
				mul_b = fhi_q;
			end
			S_V2: begin
				mul_a = a_q;
				mul_b = a_q;
			end
			S_V4: begin
				mul_a = a_q;
				mul_b = t1_q;
			end
			S_V5: begin
				mul_a = b_q;
				mul_b = b_q;
			end
			S_V7: begin
				mul_a = b_q;
				mul_b = t1_q;
			end
			S_V8: begin
				mul_a = t2_q;
				mul_b = clo_q;
			end
			S_V9: begin
				mul_a = t1_q;
				mul_b = chi_q;
			end
			S_V11: begin
				mul_a = t1_q;
				mul_b = dxs_q;
			end
			S_V12: begin
				mul_a = prod;
				mul_b = dxs_q;
			end
			S_D1: begin
				mul_a = a_q;
				mul_b = a_q;
			end
			S_D2: begin
				mul_a = b_q;
				mul_b = b_q;
			end
			S_D4: begin
				mul_a = t2_q;
				mul_b = chi_q;
			end
			S_D5: begin
				mul_a = t1_q;
				mul_b = clo_q;
			end
			S_D7: begin
				mul_a = t1_q;
				mul_b = quot6_q;
			end
			S_C1: begin
				mul_a = b_q;
				mul_b = chi_q;
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			node_count_q <= csp_pkg::CNT_W'(2);
		else if (cfg_wen)
			node_count_q <= cfg_data;
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE:  if (accept && item.command != csp_pkg::CMD_LOAD) state_q <= S_SRCH;
				S_SRCH:  state_q <= span_wide ? S_CMP : S_RDLO;
				S_CMP:   state_q <= S_SRCH;
				S_RDLO:  state_q <= S_RDHI;
				S_RDHI:  state_q <= S_GOTHI;
				S_GOTHI: state_q <= S_DX;
				S_DX:    state_q <= S_DA;
				S_DA: begin
					if (dx_q == '0) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						ret_q   <= S_DB;
						state_q <= S_DIVW;
					end
				end
				S_DB: begin
					ret_q   <= S_OP;
					state_q <= S_DIVW;
				end
				S_DIVW: if (div_done) state_q <= ret_q;
				S_OP: begin
					case (cmd_q)
						csp_pkg::CMD_VALUE: state_q <= S_V1;
						csp_pkg::CMD_SLOPE: begin
							ret_q   <= S_D1;
							state_q <= S_DIVW;
						end
						default: state_q <= S_C1;
					endcase
				end
				S_V14: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_D8, S_C2: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_V1, S_V2, S_V3, S_V4, S_V5, S_V6, S_V7, S_V8, S_V9, S_V10, S_V11, S_V12,
				S_V13, S_D1, S_D2, S_D3, S_D4, S_D5, S_D6, S_D7, S_C1:
					state_q <= state_q + 1'b1;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q <= item.command;
				x_q   <= item.query_pos;
				lo_q  <= '0;
				hi_q  <= last_idx;
			end
			S_CMP: begin
				if (pos_rd > x_q)
					hi_q <= mid;
				else
					lo_q <= mid;
			end
			S_RDHI: begin
				xlo_q <= pos_rd;
				flo_q <= val_rd;
				clo_q <= curv_rd;
			end
			S_GOTHI: begin
				xhi_q <= pos_rd;
				fhi_q <= val_rd;
				chi_q <= curv_rd;
			end
			S_DX: begin
				dx_q  <= csp_pkg::den_t'(xhi_q) - csp_pkg::den_t'(xlo_q);
				dxs_q <= csp_pkg::sat_sum(csp_pkg::sum_t'(xhi_q) - csp_pkg::sum_t'(xlo_q));
			end
			S_DA: begin
				result_q.result_value     <= '0;
				result_q.zero_width_error <= 1'b1;
			end
			S_DB: a_q <= quot;
			S_OP: begin
				b_q                       <= quot;
				result_q.zero_width_error <= 1'b0;
			end
			// value: linear part, cubic weights, correction
			S_V1:  t1_q  <= prod;
			S_V2:  lin_q <= csp_pkg::sat_sum(csp_pkg::sum_t'(t1_q) + csp_pkg::sum_t'(prod));
			S_V3:  t1_q  <= prod_m1;
			S_V5:  t2_q  <= prod;
			S_V6:  t1_q  <= prod_m1;
			S_V8:  t1_q  <= prod;
			S_V9:  t2_q  <= prod;
			S_V10: t1_q  <= csp_pkg::sat_sum(csp_pkg::sum_t'(t2_q) + csp_pkg::sum_t'(prod));
			S_V13: quot6_q <= div6_res;
			S_V14: result_q.result_value <=
				csp_pkg::sat_sum(csp_pkg::sum_t'(lin_q) + csp_pkg::sum_t'(quot6_q));
			// first derivative
			S_D1:  slope_q <= quot;
			S_D2:  t1_q    <= prod3_m1;
			S_D3:  t2_q    <= prod3_m1;
			S_D5:  t2_q    <= prod;
			S_D6: begin
				t1_q    <= csp_pkg::sat_sum(csp_pkg::sum_t'(t2_q) - csp_pkg::sum_t'(prod));
				quot6_q <= div6_res;
			end
			S_D8:  result_q.result_value <=
				csp_pkg::sat_sum(csp_pkg::sum_t'(slope_q) + csp_pkg::sum_t'(prod));
			// second derivative
			S_C1:  t1_q <= prod;
			S_C2:  result_q.result_value <=
				csp_pkg::sat_sum(csp_pkg::sum_t'(t1_q) + csp_pkg::sum_t'(prod));
			default: begin
				t1_q <= t1_q;
			end
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

/* tb/tb_cubic_spline_evaluator_top.sv */
`timescale 1ns / 1ps
module tb_cubic_spline_evaluator_top;
	import csp_pkg::*;

	localparam int IDLE_LIMIT  = 20000;
	localparam int DRAIN_WAIT  = 400;
	localparam int RAND_ITEMS  = 1050;

	typedef enum int {TBL_SORTED, TBL_DUPS, TBL_SHUFFLED, TBL_SPREAD} table_kind_e;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	item_t               item = '0;
	logic                done;
	result_t             result;
	logic                cfg_wen = 1'b0;
	logic [CNT_W-1:0]    cfg_data = '0;

	// words waiting for the driver, and results waiting for the block
	item_t   word_q[$];
	result_t spline_expect_q[$];

	// shadow copy of the node tables and node count
	data_t            pos_shadow[MAX_NODES];
	data_t            value_shadow[MAX_NODES];
	data_t            curv_shadow[MAX_NODES];
	logic [CNT_W-1:0] count_shadow = CNT_W'(2);

	int sent_n = 0;
	int took_n = 0;
	int gap_left = 0;
	bit no_gaps = 1'b0;
	int mismatches = 0;
	int idle_cycles = 0;

	cubic_spline_evaluator_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.done     (done),
		.result   (result),
		.cfg_wen  (cfg_wen),
		.cfg_data (cfg_data)
	);

	always #2 clk = ~clk;

	// fixed-point helpers on wide signed integers
	function automatic longint clamp32(input longint v);
		if (v > longint'(SAT_HI)) return longint'(SAT_HI);
		if (v < longint'(SAT_LO)) return longint'(SAT_LO);
		return v;
	endfunction

	function automatic longint fx_mul(input longint a, input longint b);
		longint p;
		p = a * b;
		return clamp32(p >>> FRAC_W);
	endfunction

	function automatic longint fx_div(input longint n, input longint d);
		return clamp32((n * 65536) / d);
	endfunction

	// spline prediction for one query word
	function automatic result_t spline_predict(input item_t w);
		result_t r;
		int n, lo, hi, mid;
		longint x, xlo, xhi, dx, dxs, a, b, flo, fhi, clo, chi, res;
		longint lin, c, d, s, ta, tb, slope;
		n = int'(count_shadow);
		if (n < 2) n = 2;
		if (n > MAX_NODES) n = MAX_NODES;
		x = w.query_pos;
		lo = 0;
		hi = n - 1;
		while (hi - lo > 1) begin
			mid = (hi + lo) >> 1;
			if (longint'(pos_shadow[mid]) > x) hi = mid;
			else lo = mid;
		end
		xlo = pos_shadow[lo];
		xhi = pos_shadow[hi];
		dx = xhi - xlo;
		r = '0;
		if (dx == 0) begin
			r.zero_width_error = 1'b1;
			return r;
		end
		dxs = clamp32(dx);
		a = fx_div(xhi - x, dx);
		b = fx_div(x - xlo, dx);
		flo = value_shadow[lo];
		fhi = value_shadow[hi];
		clo = curv_shadow[lo];
		chi = curv_shadow[hi];
		if (w.command == CMD_VALUE) begin
			lin = clamp32(fx_mul(a, flo) + fx_mul(b, fhi));
			c = fx_mul(a, clamp32(fx_mul(a, a) - longint'(ONE_Q)));
			d = fx_mul(b, clamp32(fx_mul(b, b) - longint'(ONE_Q)));
			s = clamp32(fx_mul(c, clo) + fx_mul(d, chi));
			res = clamp32(lin + fx_mul(fx_mul(s, dxs), dxs) / 6);
		end else if (w.command == CMD_SLOPE) begin
			slope = fx_div(fhi - flo, dx);
			ta = clamp32(3 * fx_mul(a, a) - longint'(ONE_Q));
			tb = clamp32(3 * fx_mul(b, b) - longint'(ONE_Q));
			s = clamp32(fx_mul(tb, chi) - fx_mul(ta, clo));
			res = clamp32(slope + fx_mul(s, dxs / 6));
		end else begin
			res = clamp32(fx_mul(a, clo) + fx_mul(b, chi));
		end
		r.result_value = data_t'(res);
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (no_gaps || r < 60) return 0;
		if (r < 90) return $urandom_range(3, 1);
		return $urandom_range(60, 10);
	endfunction

	// word builders; unused fields carry random bits
	function automatic item_t load_word(input int idx, input data_t p, input data_t v,
			input data_t c);
		item_t w;
		logic [159:0] rnd;
		rnd = {$urandom, $urandom, $urandom, $urandom, $urandom};
		w = rnd[$bits(item_t)-1:0];
		w.command = CMD_LOAD;
		w.node_index = ADDR_W'(idx);
		w.node_pos = p;
		w.node_value = v;
		w.node_curvature = c;
		return w;
	endfunction

	function automatic item_t query_word(input logic [1:0] cmd, input data_t x);
		item_t w;
		logic [159:0] rnd;
		rnd = {$urandom, $urandom, $urandom, $urandom, $urandom};
		w = rnd[$bits(item_t)-1:0];
		w.command = cmd;
		w.query_pos = x;
		return w;
	endfunction

	// driver: present the next word at the falling edge, hold until taken
	always @(negedge clk) begin
		if (arst_n && sent_n == took_n) begin
			if (gap_left > 0) begin
				start <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (word_q.size() > 0) begin
				item <= word_q.pop_front();
				start <= 1'b1;
				sent_n <= sent_n + 1;
				gap_left <= pick_gap();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: check results, then predict for the word taken at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			result_t want;
			if (done || (start && !busy))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (done) begin
				if (spline_expect_q.size() == 0) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10)
						$display("unexpected result word %h", result);
				end else begin
					want = spline_expect_q.pop_front();
					if (result.result_value !== want.result_value ||
							result.zero_width_error !== want.zero_width_error) begin
						mismatches = mismatches + 1;
						if (mismatches <= 10)
							$display("result mismatch: expected %h/%b got %h/%b",
								want.result_value, want.zero_width_error,
								result.result_value, result.zero_width_error);
					end
				end
			end
			if (start && !busy) begin
				took_n <= took_n + 1;
				if (item.command == CMD_LOAD) begin
					pos_shadow[item.node_index] = item.node_pos;
					value_shadow[item.node_index] = item.node_value;
					curv_shadow[item.node_index] = item.node_curvature;
				end else begin
					spline_expect_q.push_back(spline_predict(item));
				end
			end
		end
	end

	// watchdog on cycles with no word taken and no result
	always @(posedge clk) begin
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[cubic_spline_evaluator_top] ERROR");
			$finish;
		end
	end

	task automatic wait_idle();
		while (word_q.size() > 0 || sent_n != took_n || spline_expect_q.size() > 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_count(input int n);
		wait_idle();
		cfg_data <= CNT_W'(n);
		cfg_wen <= 1'b1;
		count_shadow = CNT_W'(n);
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	// fill all slots with a table of the given shape, in random slot order
	task automatic load_table(input table_kind_e kind);
		data_t p[MAX_NODES];
		int order[MAX_NODES];
		longint acc;
		int j, t;
		acc = (kind == TBL_SPREAD) ? longint'(SAT_LO) : $signed($urandom) >>> 2;
		for (int i = 0; i < MAX_NODES; i++) begin
			case (kind)
				TBL_SPREAD: begin
					p[i] = (i == MAX_NODES - 1) ? SAT_HI : data_t'(acc);
					acc = acc + 64'd67108864 + $urandom_range(65535);
				end
				TBL_SHUFFLED: p[i] = $urandom;
				default: begin
					p[i] = data_t'(clamp32(acc));
					if (!(kind == TBL_DUPS && $urandom_range(3) == 0))
						acc = acc + $urandom_range(1, 1 << $urandom_range(20, 2));
				end
			endcase
			order[i] = i;
		end
		for (int i = MAX_NODES - 1; i > 0; i--) begin
			j = $urandom_range(i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		for (int i = 0; i < MAX_NODES; i++) begin
			j = order[i];
			if ($urandom_range(3) == 0)
				word_q.push_back(load_word(j, p[j], $urandom, $urandom));
			else
				word_q.push_back(load_word(j, p[j], $signed($urandom) >>> $urandom_range(16, 8),
					$signed($urandom) >>> $urandom_range(16, 8)));
		end
	endtask

	// query position near a random node in use, beyond the ends, or anywhere
	function automatic data_t pick_query_pos(input int n);
		int k, r;
		if (n < 2) n = 2;
		if (n > MAX_NODES) n = MAX_NODES;
		r = $urandom_range(99);
		k = $urandom_range(n - 1);
		if (r < 20) return pos_shadow[k];
		if (r < 70) return data_t'(clamp32(longint'(pos_shadow[k]) +
			($signed($urandom) >>> $urandom_range(31, 10))));
		if (r < 80) return data_t'(clamp32(longint'(pos_shadow[0]) -
			$urandom_range(1 << 20)));
		if (r < 90) return data_t'(clamp32(longint'(pos_shadow[n - 1]) +
			$urandom_range(1 << 20)));
		return $urandom;
	endfunction

	initial begin
		int counts[5] = '{2, 64, 0, 1, 127};
		int total, n, nq;
		table_kind_e kind;
		logic [1:0] cmd;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: two-node table, every command, field extremes, zero width
		write_count(2);
		word_q.push_back(load_word(0, 32'sd0, ONE_Q, SAT_LO));
		word_q.push_back(load_word(1, 32'sh0004_0000, SAT_HI, SAT_HI));
		word_q.push_back(load_word(63, SAT_HI, SAT_LO, SAT_HI));
		word_q.push_back(query_word(CMD_VALUE, 32'sd0));
		word_q.push_back(query_word(CMD_VALUE, 32'sh0002_0000));
		word_q.push_back(query_word(CMD_VALUE, 32'sh0004_0000));
		word_q.push_back(query_word(CMD_VALUE, SAT_LO));
		word_q.push_back(query_word(CMD_SLOPE, SAT_HI));
		word_q.push_back(query_word(CMD_SLOPE, 32'sh0001_0000));
		word_q.push_back(query_word(CMD_CURV, 32'sh0003_0000));
		word_q.push_back(query_word(CMD_CURV, SAT_LO));
		word_q.push_back(load_word(1, 32'sd0, -32'sd1, 32'sd7));
		word_q.push_back(query_word(CMD_VALUE, 32'sd0));
		word_q.push_back(query_word(CMD_SLOPE, 32'sh0001_0000));
		word_q.push_back(query_word(CMD_CURV, -32'sd5));
		word_q.push_back(load_word(0, SAT_LO, SAT_HI, SAT_LO));
		word_q.push_back(load_word(1, SAT_HI, SAT_LO, SAT_HI));
		word_q.push_back(query_word(CMD_VALUE, 32'sd0));
		word_q.push_back(query_word(CMD_SLOPE, SAT_HI));
		word_q.push_back(query_word(CMD_CURV, 32'sd1));
		wait_idle();

		// random phases: a new table, a node count, then a burst of queries
		total = 0;
		for (int ph = 0; total < RAND_ITEMS; ph++) begin
			n = (ph < 5) ? counts[ph] : $urandom_range(127);
			kind = table_kind_e'($urandom_range(3));
			no_gaps = ($urandom_range(3) == 0);
			write_count(n);
			load_table(kind);
			total += MAX_NODES;
			wait_idle();
			nq = $urandom_range(50, 25);
			for (int q = 0; q < nq; q++) begin
				cmd = 2'($urandom_range(3, 1));
				if ($urandom_range(19) == 0) begin
					// stray rewrite of one random slot, keeping its position
					n = $urandom_range(MAX_NODES - 1);
					word_q.push_back(load_word(n, pos_shadow[n], $urandom, $urandom));
				end else begin
					word_q.push_back(query_word(cmd, pick_query_pos(int'(count_shadow))));
				end
			end
			total += nq;
		end

		wait_idle();
		repeat (DRAIN_WAIT) @(negedge clk);
		if (mismatches == 0 && spline_expect_q.size() == 0)
			$display("[cubic_spline_evaluator_top] OK");
		else
			$display("[cubic_spline_evaluator_top] ERROR");
		$finish;
	end

endmodule

/* sim.f */
src/csp_pkg.sv
src/csp_ram.sv
src/csp_mul.sv
src/csp_div.sv
src/cubic_spline_evaluator_top.sv
tb/tb_cubic_spline_evaluator_top.sv
